// ===== hw/rtl/panic_button_press_classifier_top_macros.svh =====
// assertion macros for the panic button press classifier
// each macro expects clk and rst in the scope where it is used
`ifndef PANIC_BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define PANIC_BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PBPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbpc same-cycle check failed");

// next-cycle implication, disabled during reset
`define PBPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbpc next-cycle check failed");

`endif

// ===== hw/rtl/pbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpc_pkg
// constants for the panic button press classifier: press windows, opcodes,
// register map and counter limits
// ----------------------------------------------------------------------------
`default_nettype none

package pbpc_pkg;

  localparam int HeldW    = 5;
  localparam int ElapsedW = 16;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [HeldW-1:0] MIN_PRESS_TICKS = 5'd2;
  localparam logic [HeldW-1:0] MAX_PRESS_TICKS = 5'd20;
  localparam logic [HeldW-1:0] TAMPER_TICKS    = 5'd21;
  localparam logic [HeldW-1:0] HELD_SAT        = 5'd31;

  localparam logic [ElapsedW-1:0] ELAPSED_SAT     = 16'hFFFF;
  localparam logic [ElapsedW-1:0] TIMEOUT_DEFAULT = 16'd600;

  // item opcodes
  localparam logic OPC_TICK  = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_DISABLE = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/panic_button_press_classifier_top.sv =====
// ----------------------------------------------------------------------------
// panic_button_press_classifier_top
// classifies panic button presses per tick into alarm and tamper events,
// with alarm timeout, early clear and a disable register on an apb port
// ----------------------------------------------------------------------------
// output: the result of an item is registered into the output register
//   in the cycle after the item is accepted
// throughput: one item per cycle while each result is taken (out_ready); the state
//   update and classification sit between the state registers and the output register
// reset: synchronous rst clears state, flags and out_valid, and loads
//   disable_cfg = 0 and alarm_timeout_ticks = 600
`default_nettype none
`include "panic_button_press_classifier_top_macros.svh"

module panic_button_press_classifier_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // apb configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pbpc_pkg::AddrW-1:0]   paddr,
  input  wire logic [pbpc_pkg::DataW-1:0]   pwdata,
  output logic      [pbpc_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         opcode,
  input  wire logic                         button_level,
  input  wire logic                         emergency_link_up,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              alarm_active,
  output logic                              tamper_active,
  output logic                              alarm_on_event,
  output logic                              alarm_off_event,
  output logic                              tamper_on_event,
  output logic                              tamper_off_event,
  output logic                              sms_fallback
);
  import pbpc_pkg::*;

  // configuration registers
  logic                disable_cfg;
  logic [ElapsedW-1:0] alarm_timeout_ticks;

  // classifier state
  logic [HeldW-1:0]    held_ticks;
  logic                alarm_flag;
  logic                tamper_flag;
  logic [ElapsedW-1:0] alarm_elapsed;

  logic [HeldW-1:0]    held_ticks_next;
  logic                alarm_flag_next;
  logic                tamper_flag_next;
  logic [ElapsedW-1:0] alarm_elapsed_next;

  logic [HeldW-1:0]    held_inc;
  logic [ElapsedW-1:0] elapsed_step;
  logic                run_timeout;
  logic                a_on, a_off, t_on, t_off, sms;

  logic cfg_write;
  logic in_accept;

  // apb
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_DISABLE: prdata = {{(DataW-1){1'b0}}, disable_cfg};
      REG_TIMEOUT: prdata = {{(DataW-ElapsedW){1'b0}}, alarm_timeout_ticks};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disable_cfg         <= 1'b0;
      alarm_timeout_ticks <= TIMEOUT_DEFAULT;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DISABLE: disable_cfg         <= pwdata[0];
        REG_TIMEOUT: alarm_timeout_ticks <= pwdata[ElapsedW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: output register frees up when its item is taken
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign held_inc = (held_ticks == HELD_SAT) ? held_ticks : held_ticks + 5'd1;

  always_comb begin
    held_ticks_next    = held_ticks;
    alarm_flag_next    = alarm_flag;
    tamper_flag_next   = tamper_flag;
    alarm_elapsed_next = alarm_elapsed;
    elapsed_step       = alarm_elapsed;
    run_timeout        = 1'b1;
    a_on               = 1'b0;
    a_off              = 1'b0;
    t_on               = 1'b0;
    t_off              = 1'b0;
    sms                = 1'b0;

    if (opcode == OPC_CLEAR) begin
      if (alarm_flag) begin
        alarm_elapsed_next = alarm_timeout_ticks;
      end
      run_timeout = 1'b0;
    end else if (disable_cfg) begin
      if (alarm_flag || tamper_flag) begin
        alarm_flag_next    = 1'b0;
        tamper_flag_next   = 1'b0;
        held_ticks_next    = '0;
        alarm_elapsed_next = '0;
        a_off              = 1'b1;
        t_off              = 1'b1;
      end
      run_timeout = 1'b0;
    end else if (button_level) begin
      held_ticks_next = held_inc;
      // held too long: tamper, restart count, no timeout step
      if (held_inc > TAMPER_TICKS) begin
        held_ticks_next = '0;
        if (!tamper_flag) begin
          if (alarm_flag) begin
            alarm_flag_next = 1'b0;
            a_off           = 1'b1;
          end
          tamper_flag_next = 1'b1;
          t_on             = 1'b1;
        end
        run_timeout = 1'b0;
      end
    end else begin
      if (held_ticks >= MIN_PRESS_TICKS && held_ticks < MAX_PRESS_TICKS &&
          !alarm_flag && !tamper_flag) begin
        alarm_flag_next    = 1'b1;
        a_on               = 1'b1;
        sms                = !emergency_link_up;
        alarm_elapsed_next = '0;
      end
      held_ticks_next = '0;
      if (tamper_flag) begin
        tamper_flag_next = 1'b0;
        t_off            = 1'b1;
      end
    end

    // alarm timeout, saturating elapsed count
    if (run_timeout && alarm_flag_next) begin
      elapsed_step = (alarm_elapsed_next == ELAPSED_SAT) ?
                     alarm_elapsed_next : alarm_elapsed_next + 16'd1;
      if (elapsed_step >= alarm_timeout_ticks) begin
        alarm_elapsed_next = '0;
        alarm_flag_next    = 1'b0;
        a_off              = 1'b1;
      end else begin
        alarm_elapsed_next = elapsed_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_ticks    <= '0;
      alarm_flag    <= 1'b0;
      tamper_flag   <= 1'b0;
      alarm_elapsed <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        held_ticks    <= held_ticks_next;
        alarm_flag    <= alarm_flag_next;
        tamper_flag   <= tamper_flag_next;
        alarm_elapsed <= alarm_elapsed_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      alarm_active     <= alarm_flag_next;
      tamper_active    <= tamper_flag_next;
      alarm_on_event   <= a_on;
      alarm_off_event  <= a_off;
      tamper_on_event  <= t_on;
      tamper_off_event <= t_off;
      sms_fallback     <= sms;
    end
  end

  `PBPC_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
  `PBPC_ASSERT_NOW(a_tamper_on_state, out_valid && tamper_on_event, tamper_active)
  `PBPC_ASSERT_NOW(a_tamper_off_state, out_valid && tamper_off_event, !tamper_active)
  `PBPC_ASSERT_NOW(a_sms_needs_alarm, out_valid && sms_fallback,
                   alarm_on_event && !tamper_active)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the panic button press classifier: drives tick and
// clear items over valid/ready, predicts each result item from its own model
// of the press, alarm and tamper state, and compares every field
// ----------------------------------------------------------------------------

module tb_top;
  import pbpc_pkg::*;

  typedef struct packed {
    logic alarm;
    logic tamper;
    logic alarm_on;
    logic alarm_off;
    logic tamper_on;
    logic tamper_off;
    logic sms;
  } verdict_t;

  // press classifier state plus the verdicts still owed by the block
  class press_verdicts;
    logic                disabled;
    logic [ElapsedW-1:0] timeout;
    logic [HeldW-1:0]    held;
    logic                alarm;
    logic                tamper;
    logic [ElapsedW-1:0] elapsed;
    verdict_t            due[$];
    int                  errors;
    int                  checked;

    function new();
      disabled = 1'b0;
      timeout  = TIMEOUT_DEFAULT;
      held     = '0;
      alarm    = 1'b0;
      tamper   = 1'b0;
      elapsed  = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void load_reg(logic idx, logic [ElapsedW-1:0] val);
      if (idx == REG_DISABLE) disabled = val[0];
      else timeout = val;
    endfunction

    function void take_item(logic op, logic btn, logic link);
      verdict_t v;
      bit       timing;
      v = '0;
      timing = 1'b1;
      if (op == OPC_CLEAR) begin
        if (alarm) elapsed = timeout;
        timing = 1'b0;
      end else if (disabled) begin
        if (alarm || tamper) begin
          alarm = 1'b0;
          tamper = 1'b0;
          held = '0;
          elapsed = '0;
          v.alarm_off = 1'b1;
          v.tamper_off = 1'b1;
        end
        timing = 1'b0;
      end else if (btn) begin
        if (held != HELD_SAT) held++;
        // held too long: tamper, count restarts, no timeout step
        if (held > TAMPER_TICKS) begin
          held = '0;
          if (!tamper) begin
            if (alarm) begin
              alarm = 1'b0;
              v.alarm_off = 1'b1;
            end
            tamper = 1'b1;
            v.tamper_on = 1'b1;
          end
          timing = 1'b0;
        end
      end else begin
        if (held >= MIN_PRESS_TICKS && held < MAX_PRESS_TICKS && !alarm && !tamper) begin
          alarm = 1'b1;
          v.alarm_on = 1'b1;
          v.sms = !link;
          elapsed = '0;
        end
        held = '0;
        if (tamper) begin
          tamper = 1'b0;
          v.tamper_off = 1'b1;
        end
      end
      if (timing && alarm) begin
        if (elapsed != ELAPSED_SAT) elapsed++;
        if (elapsed >= timeout) begin
          elapsed = '0;
          alarm = 1'b0;
          v.alarm_off = 1'b1;
        end
      end
      v.alarm = alarm;
      v.tamper = tamper;
      due.push_back(v);
    endfunction

    function void compare_bit(string field, logic got, logic want);
      if (got !== want)
        report($sformatf("result %0d: %s is %b, predicted %b", checked, field, got, want));
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        report("result item with no input item waiting");
        return;
      end
      want = due.pop_front();
      compare_bit("alarm_active", got.alarm, want.alarm);
      compare_bit("tamper_active", got.tamper, want.tamper);
      compare_bit("alarm_on_event", got.alarm_on, want.alarm_on);
      compare_bit("alarm_off_event", got.alarm_off, want.alarm_off);
      compare_bit("tamper_on_event", got.tamper_on, want.tamper_on);
      compare_bit("tamper_off_event", got.tamper_off, want.tamper_off);
      compare_bit("sms_fallback", got.sms, want.sms);
      checked++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic                opcode;
  logic                button_level;
  logic                emergency_link_up;
  logic                out_valid;
  logic                out_ready;
  logic                alarm_active;
  logic                tamper_active;
  logic                alarm_on_event;
  logic                alarm_off_event;
  logic                tamper_on_event;
  logic                tamper_off_event;
  logic                sms_fallback;

  press_verdicts book = new();
  int            sent = 0;
  bit            src_idle = 1'b0;
  bit            snk_idle = 1'b0;
  int            hold_req = 0;

  panic_button_press_classifier_top uut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .button_level     (button_level),
    .emergency_link_up(emergency_link_up),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .alarm_active     (alarm_active),
    .tamper_active    (tamper_active),
    .alarm_on_event   (alarm_on_event),
    .alarm_off_event  (alarm_off_event),
    .tamper_on_event  (tamper_on_event),
    .tamper_off_event (tamper_off_event),
    .sms_fallback     (sms_fallback)
  );

  always #5 clk = ~clk;

  // results checked before the item of the same edge is booked
  always @(posedge clk) begin : watch
    verdict_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.alarm      = alarm_active;
        seen.tamper     = tamper_active;
        seen.alarm_on   = alarm_on_event;
        seen.alarm_off  = alarm_off_event;
        seen.tamper_on  = tamper_on_event;
        seen.tamper_off = tamper_off_event;
        seen.sms        = sms_fallback;
        book.match_verdict(seen);
      end
      if (in_valid && in_ready) book.take_item(opcode, button_level, emergency_link_up);
    end
  end

  // result side: random stalls per item while snk_idle is set, plus one long hold-off on request
  initial begin : sink
    int w;
    out_ready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        out_ready = 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      w = snk_idle ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
        out_ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("panic_button_press_classifier_top: mismatch");
    $finish;
  end

  // entered and left just after a falling edge
  task automatic send_item(input logic op, input logic btn, input logic link);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    button_level = btn;
    emergency_link_up = link;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // held ticks then one release; chatter sprinkles clear requests in between
  task automatic press_and_release(input int len, input logic link, input bit chatter);
    for (int i = 0; i < len; i++) begin
      if (chatter && $urandom_range(0, 15) == 0)
        send_item(OPC_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_item(OPC_TICK, 1'b1, 1'($urandom_range(0, 1)));
    end
    send_item(OPC_TICK, 1'b0, link);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [ElapsedW-1:0] val);
    logic [DataW-1:0]    back;
    logic [ElapsedW-1:0] mask;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrW'({idx, 2'b00});
    pwdata = DataW'(val);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    // read back the same register
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    back = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    book.load_reg(idx, val);
    mask = (idx == REG_DISABLE) ? 16'h0001 : 16'hFFFF;
    if ((back[ElapsedW-1:0] & mask) != (val & mask))
      book.report($sformatf("register %0d reads %h, written %h", idx, back, val));
  endtask

  task automatic random_burst(input int n);
    int target;
    int len;
    int pick;
    target = sent + n;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(0, 1);
          6:       len = $urandom_range(20, 21);
          7, 8:    len = $urandom_range(22, 30);
          9:       len = $urandom_range(31, 50);
          default: len = $urandom_range(2, 19);
        endcase
        press_and_release(len, 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 80) begin
        send_item(OPC_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    opcode = OPC_TICK;
    button_level = 1'b0;
    emergency_link_up = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed part, no idling
    send_item(OPC_TICK, 1'b0, 1'b1);
    press_and_release(1, 1'b1, 1'b0);
    press_and_release(2, 1'b0, 1'b0);
    press_and_release(2, 1'b1, 1'b0);
    send_item(OPC_CLEAR, 1'b0, 1'b0);
    send_item(OPC_TICK, 1'b1, 1'b1);
    send_item(OPC_TICK, 1'b0, 1'b0);
    send_item(OPC_CLEAR, 1'b1, 1'b1);
    settle();
    reg_write(REG_DISABLE, 16'd1);
    send_item(OPC_TICK, 1'b1, 1'b0);
    settle();
    reg_write(REG_DISABLE, 16'd0);
    press_and_release(3, 1'b1, 1'b0);
    settle();
    reg_write(REG_DISABLE, 16'd1);
    // clear is not gated by disable; the tick after it drops the alarm
    send_item(OPC_CLEAR, 1'b0, 1'b1);
    send_item(OPC_TICK, 1'b0, 1'b1);
    settle();
    reg_write(REG_DISABLE, 16'd0);
    reg_write(REG_TIMEOUT, 16'd0);
    press_and_release(2, 1'b0, 1'b0);
    settle();
    reg_write(REG_TIMEOUT, 16'd1);
    press_and_release(2, 1'b1, 1'b0);
    settle();
    reg_write(REG_TIMEOUT, 16'hFFFF);
    // elapsed parked at its ceiling by a clear
    press_and_release(2, 1'b1, 1'b0);
    send_item(OPC_CLEAR, 1'b0, 1'b0);
    send_item(OPC_TICK, 1'b0, 1'b1);
    settle();

    // random part
    src_idle = 1'b1;
    snk_idle = 1'b1;
    reg_write(REG_TIMEOUT, 16'd3);
    random_burst(180);
    settle();

    src_idle = 1'b0;
    snk_idle = 1'b0;
    reg_write(REG_TIMEOUT, 16'd0);
    random_burst(70);
    settle();

    reg_write(REG_TIMEOUT, 16'hFFFF);
    random_burst(40);
    // long receiver hold-off while items keep coming
    hold_req = 40;
    repeat (20) send_item(OPC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    settle();
    random_burst(40);
    settle();

    snk_idle = 1'b1;
    reg_write(REG_DISABLE, 16'd1);
    random_burst(50);
    settle();

    src_idle = 1'b1;
    reg_write(REG_DISABLE, 16'd0);
    reg_write(REG_TIMEOUT, 16'($urandom_range(2, 40)));
    random_burst(150);
    settle();

    snk_idle = 1'b0;
    reg_write(REG_TIMEOUT, 16'd600);
    random_burst(150);

    settle();
    repeat (10) @(negedge clk);
    if (book.errors == 0)
      $display("panic_button_press_classifier_top: match");
    else
      $display("panic_button_press_classifier_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pbpc_pkg.sv
hw/rtl/panic_button_press_classifier_top.sv
bench/tb_top.sv
